>>> rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// Package for the WebSocket frame deframer: parse phases, header codes,
// and the result record shared by the parser and output stage.
// No dependencies.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [7:0] HDR_TEXT       = 8'h81;
  localparam logic [7:0] HDR_BINARY     = 8'h82;
  localparam logic [7:0] LEN_MASK       = 8'h7F;
  localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16      = 7'd126;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       is_binary;
  } res_t;

endpackage

>>> rtl/wsd_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer: received byte stream in,
// unmasked payload bytes out. Depends on nothing.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_of_frame;
  logic       is_binary;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output is_binary, input ready);
  modport sink   (input valid, input payload_byte, input last_of_frame,
                  input is_binary, output ready);
endinterface

>>> rtl/wsd_in_stage.sv
`timescale 1ns / 1ps
// Input register for the received byte stream. Takes a new byte whenever
// empty or when the parser consumes the held byte. Uses wsd_in_if.
module wsd_in_stage (
  input  logic        clk,
  input  logic        rst,
  wsd_in_if.sink      byte_in,
  input  logic        consume,
  output logic        valid,
  output logic [7:0]  data
);

  assign byte_in.ready = !valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_in.ready) begin
      valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready) begin
      data <= byte_in.data_byte;
    end
  end

endmodule

>>> rtl/wsd_parser.sv
`timescale 1ns / 1ps
// Frame header parser and payload unmasker. One byte per advance; holds the
// parse state, length counter and mask key. Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  data,
  output logic        res_valid,
  output res_t        res
);

  phase_t      phase, phase_next;
  logic [3:0]  len_left, len_left_next;
  logic [63:0] length, length_next;   // counts down through the payload
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_cnt, mask_cnt_next;
  logic [1:0]  key_idx, key_idx_next;
  logic        frame_ok, frame_ok_next;
  logic        frame_bin, frame_bin_next;

  logic [6:0]  len7;
  logic [7:0]  key_byte;
  logic        last;

  assign len7 = data[6:0] & LEN_MASK[6:0];
  assign last = (length == 64'd1);

  always_comb begin
    unique case (key_idx)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      len_left  <= 4'd0;
      mask_cnt  <= 2'd0;
      key_idx   <= 2'd0;
      frame_ok  <= 1'b0;
      frame_bin <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      len_left  <= len_left_next;
      mask_cnt  <= mask_cnt_next;
      key_idx   <= key_idx_next;
      frame_ok  <= frame_ok_next;
      frame_bin <= frame_bin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      length   <= length_next;
      mask_key <= mask_key_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    len_left_next  = len_left;
    length_next    = length;
    mask_key_next  = mask_key;
    mask_cnt_next  = mask_cnt;
    key_idx_next   = key_idx;
    frame_ok_next  = frame_ok;
    frame_bin_next = frame_bin;
    res_valid      = 1'b0;
    res.payload_byte  = data ^ key_byte;
    res.last_of_frame = last;
    res.is_binary     = frame_bin;

    unique case (phase)
      PH_LEN: begin
        mask_cnt_next = 2'd0;
        if (len7 <= LEN_DIRECT_MAX) begin
          length_next = {57'd0, len7};
          phase_next  = PH_MASK;
        end else begin
          length_next   = 64'd0;
          len_left_next = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_next    = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        length_next   = {length[55:0], data};
        len_left_next = len_left - 4'd1;
        if (len_left == 4'd1) begin
          phase_next = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], data};
        mask_cnt_next = mask_cnt + 2'd1;
        if (mask_cnt == 2'd3) begin
          key_idx_next = 2'd0;
          phase_next   = (length == 64'd0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid    = advance && frame_ok;
        key_idx_next = key_idx + 2'd1;
        length_next  = length - 64'd1;
        if (last) begin
          phase_next = PH_FIRST;
        end
      end
      default: begin
        // first header byte; unknown phase codes land here as well
        frame_ok_next  = (data == HDR_TEXT) || (data == HDR_BINARY);
        frame_bin_next = (data == HDR_BINARY);
        len_left_next  = 4'd0;
        phase_next     = PH_LEN;
      end
    endcase
  end

  a_payload_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> length != 64'd0)
    else $error("payload phase with zero bytes left");

  a_extlen_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EXTLEN |-> (len_left != 4'd0 && len_left <= EXT64_BYTES))
    else $error("extended length count out of range");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == PH_PAYLOAD && last) |=> phase == PH_FIRST)
    else $error("frame did not end after its last payload byte");

  a_result_only_good_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_ok && phase == PH_PAYLOAD))
    else $error("result from a rejected frame or outside payload");

endmodule

>>> rtl/wsd_out_stage.sv
`timescale 1ns / 1ps
// Result register for unmasked payload bytes. Loads whenever empty or when
// the held result is taken. Depends on wsd_pkg and wsd_out_if.
module wsd_out_stage import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  res_t        res,
  output logic        load,
  wsd_out_if.source   frame_out
);

  res_t held;

  assign load = !frame_out.valid || frame_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_out.valid <= 1'b0;
    end else if (load) begin
      frame_out.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign frame_out.payload_byte  = held.payload_byte;
  assign frame_out.last_of_frame = held.last_of_frame;
  assign frame_out.is_binary     = held.is_binary;

endmodule

>>> rtl/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the WebSocket frame deframer: input register, header parser
// with unmasking, result register. Depends on wsd_pkg, wsd_ifs and submodules.
//
//   channel    dir  payload                                   handshake
//   byte_in    in   data_byte[7:0]                            valid/ready
//   frame_out  out  payload_byte[7:0], last_of_frame, is_binary  valid/ready
//
// Accepts one byte per cycle while frame_out does not stall; a payload byte
// passes through the input register, then the result register, before it
// shows up on frame_out.
// Header, mask key and rejected-frame bytes produce no output transaction.
// rst clears the parse state to "awaiting first header byte" and empties both
// registers. A stall on frame_out backs up through both registers to byte_in.ready.
module websocket_frame_deframer_core import wsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wsd_in_if.sink    byte_in,
  wsd_out_if.source frame_out
);

  logic       in_valid;
  logic [7:0] in_data;
  logic       load;
  logic       advance;
  logic       res_valid;
  res_t       res;

  assign advance = in_valid && load;

  wsd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .consume (load),
    .valid   (in_valid),
    .data    (in_data)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .load      (load),
    .frame_out (frame_out)
  );

endmodule

>>> tb/websocket_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer_core: drives framed byte streams,
// predicts unmasked payload bytes, and checks every output transaction.
// Depends on wsd_pkg, wsd_ifs and the deframer RTL.
module websocket_frame_deframer_core_tb;
  import wsd_pkg::*;

  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         RANDOM_BYTES = 1700;
  localparam int         DRAIN_CYCLES = 8;

  typedef enum int {LEN_FORM_DIRECT, LEN_FORM_16, LEN_FORM_64} len_form_t;

  logic clk;
  logic rst;

  wsd_in_if  byte_ch ();
  wsd_out_if frame_ch ();

  websocket_frame_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .frame_out (frame_ch)
  );

  // predicted parser state
  phase_t      rx_phase    = PH_FIRST;
  logic [3:0]  len_left    = '0;
  logic [63:0] frame_len   = '0;
  logic [31:0] mask_key_r  = '0;
  logic [1:0]  key_cnt     = '0;
  logic [63:0] payload_idx = '0;
  logic        frame_ok    = 1'b0;
  logic        frame_bin   = 1'b0;

  res_t unmasked_q[$];

  int errors        = 0;
  int bytes_sent    = 0;
  int cycle_count   = 0;
  int rx_hold_cycles = 0;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL websocket_frame_deframer_core");
      $finish;
    end
  end

  function automatic void deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] key_byte;
    logic       last;
    res_t       r;
    case (rx_phase)
      PH_LEN: begin
        len7 = 7'(b & LEN_MASK);
        frame_len = '0;
        if (len7 <= LEN_DIRECT_MAX) begin
          frame_len = 64'(len7);
          rx_phase  = PH_MASK;
        end else begin
          len_left = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          rx_phase = PH_EXTLEN;
        end
        key_cnt    = '0;
        mask_key_r = '0;
      end
      PH_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        len_left  = len_left - 4'd1;
        if (len_left == 4'd0) rx_phase = PH_MASK;
      end
      PH_MASK: begin
        mask_key_r = {mask_key_r[23:0], b};
        key_cnt    = key_cnt + 2'd1;
        if (key_cnt == 2'd0) begin
          payload_idx = '0;
          rx_phase    = (frame_len == 64'd0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        key_byte = mask_key_r[8 * (3 - int'(payload_idx[1:0])) +: 8];
        last     = (payload_idx == frame_len - 64'd1);
        if (frame_ok) begin
          r.payload_byte  = b ^ key_byte;
          r.last_of_frame = last;
          r.is_binary     = frame_bin;
          unmasked_q.push_back(r);
        end
        payload_idx = payload_idx + 64'd1;
        if (last) rx_phase = PH_FIRST;
      end
      default: begin
        frame_ok  = (b == HDR_TEXT) || (b == HDR_BINARY);
        frame_bin = (b == HDR_BINARY);
        len_left  = '0;
        rx_phase  = PH_LEN;
      end
    endcase
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_idles ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input len_form_t form,
                            input logic [63:0] len, input logic mask_bit,
                            input logic [31:0] key, input int unsigned body);
    send_byte(hdr);
    case (form)
      LEN_FORM_DIRECT: send_byte({mask_bit, len[6:0]});
      LEN_FORM_16: begin
        send_byte({mask_bit, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask_bit, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (body) send_byte(8'($urandom));
  endtask

  // receiver: random stall before each transaction, plus requested long holds
  initial begin
    int stall;
    frame_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = receiver_idles ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      @(posedge clk);
      while (!frame_ch.valid && rx_hold_cycles == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (unmasked_q.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual %h/%b/%b", $time,
                 frame_ch.payload_byte, frame_ch.last_of_frame, frame_ch.is_binary);
        errors++;
      end else begin
        want = unmasked_q.pop_front();
        if (want.payload_byte !== frame_ch.payload_byte ||
            want.last_of_frame !== frame_ch.last_of_frame ||
            want.is_binary !== frame_ch.is_binary) begin
          $display("%0t: mismatch byte/last/bin expected %h/%b/%b actual %h/%b/%b",
                   $time, want.payload_byte, want.last_of_frame, want.is_binary,
                   frame_ch.payload_byte, frame_ch.last_of_frame, frame_ch.is_binary);
          errors++;
        end
      end
    end
  end

  task automatic test_header_cases();
    // zero length with mask bit set, then binary, a rejected header, zero key
    send_frame(HDR_TEXT, LEN_FORM_DIRECT, 64'd0, 1'b1, 32'h0123_4567, 0);
    send_frame(HDR_BINARY, LEN_FORM_DIRECT, 64'd2, 1'b0, 32'hFFFF_FFFF, 2);
    send_frame(8'h00, LEN_FORM_DIRECT, 64'd1, 1'b0, 32'h0000_0000, 1);
    send_frame(HDR_TEXT, LEN_FORM_DIRECT, 64'd5, 1'b1, 32'h0000_0000, 5);
  endtask

  task automatic test_extended_lengths();
    send_frame(HDR_TEXT, LEN_FORM_16, 64'd0, 1'b1, $urandom, 0);
    send_frame(HDR_BINARY, LEN_FORM_16, 64'd3, 1'b0, $urandom, 3);
    send_frame(HDR_TEXT, LEN_FORM_16, 64'd256, 1'b1, $urandom, 256);
    send_frame(HDR_BINARY, LEN_FORM_64, 64'd0, 1'b1, $urandom, 0);
    send_frame(HDR_TEXT, LEN_FORM_64, 64'd2, 1'b0, $urandom, 2);
    send_frame(8'hFF, LEN_FORM_64, 64'd3, 1'b1, $urandom, 3);
    send_frame(HDR_BINARY, LEN_FORM_DIRECT, 64'(LEN_DIRECT_MAX), 1'b0, $urandom,
               32'(LEN_DIRECT_MAX));
  endtask

  task automatic test_random_frames();
    int          frames;
    logic [7:0]  hdr;
    len_form_t   form;
    logic [63:0] len;
    int          pick;
    frames = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (frames % 8 == 0) begin
        sender_idles   = ($urandom_range(0, 2) != 0);
        receiver_idles = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 9);
      hdr  = (pick < 4) ? HDR_TEXT : (pick < 8) ? HDR_BINARY : 8'($urandom);
      pick = $urandom_range(0, 9);
      form = (pick < 6) ? LEN_FORM_DIRECT : (pick < 8) ? LEN_FORM_16 : LEN_FORM_64;
      if (form == LEN_FORM_DIRECT)
        len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
                                          : 64'($urandom_range(0, 16));
      else
        len = 64'($urandom_range(0, 24));
      send_frame(hdr, form, len, 1'($urandom), $urandom, 32'(len));
      frames++;
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender streams without gaps
    sender_idles   = 1'b0;
    rx_hold_cycles = 200;
    send_frame(HDR_TEXT, LEN_FORM_DIRECT, 64'd64, 1'b1, $urandom, 64);
    sender_idles = 1'b1;
  endtask

  task automatic test_huge_length();
    // 64-bit length with the top bit set; frame never completes, last stays low
    send_frame(HDR_BINARY, LEN_FORM_64, 64'h8000_0000_0000_0001, 1'b1, $urandom, 40);
  endtask

  initial begin
    rst               <= 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_header_cases();
    test_extended_lengths();
    test_random_frames();
    test_backpressure();
    test_huge_length();

    byte_ch.valid <= 1'b0;
    while (unmasked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && unmasked_q.size() == 0) begin
      $display("PASS websocket_frame_deframer_core");
    end else begin
      $display("FAIL websocket_frame_deframer_core");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/wsd_pkg.sv
rtl/wsd_ifs.sv
rtl/wsd_in_stage.sv
rtl/wsd_parser.sv
rtl/wsd_out_stage.sv
rtl/websocket_frame_deframer_core.sv
tb/websocket_frame_deframer_core_tb.sv
